@@ src/cfdc_pkg.sv @@
// Shared types, constants and the check-byte update for the command frame deframer.
package cfdc_pkg;

	// Frame layout: one check byte followed by ten payload bytes.
	localparam int unsigned FRAME_BYTES = 11;
	localparam int unsigned CNT_W       = 4;
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0] CHECK_IDX = '0;

	// Payload positions that are held in registers before the last byte arrives.
	localparam int unsigned PAY_FIRST = 1;
	localparam int unsigned PAY_LAST  = 9;

	// Reset and reject values.
	localparam logic [7:0]         START_RESET = 8'd35;
	localparam logic signed [7:0]  BYTE_NONE   = -8'sd1;
	localparam logic signed [15:0] ANGLE_RESET = 16'sd90;

	typedef enum logic {
		ST_HUNT,
		ST_COLLECT
	} state_t;

	// One result beat.
	typedef struct packed {
		logic               frame_ok;
		logic signed [7:0]  motion_kind;
		logic signed [7:0]  move_value;
		logic signed [15:0] arm_angle_one;
		logic signed [15:0] arm_angle_two;
		logic signed [15:0] arm_angle_three;
		logic signed [7:0]  arm_setting;
		logic signed [7:0]  audio_mode;
	} result_t;

	// Two shift-and-or steps (by 3, then by 4) folded into one 8-bit update.
	function automatic logic [7:0] chk_step(input logic [7:0] ch, input logic [7:0] b);
		chk_step = {ch[0], 7'b0} | {b[3:0], 4'b0} | b;
	endfunction

endpackage

@@ src/command_frame_deframer_checker.sv @@
// Top level of the command frame deframer and checker.
//
// Takes one received byte per beat and sustains one byte per clock cycle while rx is
// not stalled. A byte is registered at the input, then the frame tracker handles it
// and, for the last byte of a frame, loads the result register, which holds the
// result beat. The hunt drops everything but the start symbol; then a check byte and
// ten payload bytes are collected, and one result beat follows each frame. A rejected
// frame reports frame_ok low, with motion kind, move value and audio mode at -1 and
// the arm fields unchanged. rx stalls only while the last byte of a frame waits on a
// result that has not yet been taken.
module command_frame_deframer_checker
	import cfdc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               frame_ok,
	output logic signed [7:0]  motion_kind,
	output logic signed [7:0]  move_value,
	output logic signed [15:0] arm_angle_one,
	output logic signed [15:0] arm_angle_two,
	output logic signed [15:0] arm_angle_three,
	output logic signed [7:0]  arm_setting,
	output logic signed [7:0]  audio_mode
);

	logic [7:0] start_sym_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	result_t    out_q;
	logic       out_free;
	logic       drain;
	logic       last_byte;
	logic       done;
	result_t    result;

	// Start symbol register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_sym_q <= START_RESET;
		end else if (cfg_we) begin
			start_sym_q <= cfg_wdata;
		end
	end

	// The input stage moves on unless it holds a frame's last byte and the result
	// register is still occupied.
	assign out_free = !out_valid_q || !out_stall;
	assign drain    = valid_s1 && (!last_byte || out_free);
	assign in_stall = valid_s1 && !drain;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) byte_s1 <= rx_byte;
	end

	cfdc_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (drain),
		.byte_data    (byte_s1),
		.start_symbol (start_sym_q),
		.last_byte    (last_byte),
		.done         (done),
		.result       (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) out_q <= result;
	end

	assign out_valid       = out_valid_q;
	assign frame_ok        = out_q.frame_ok;
	assign motion_kind     = out_q.motion_kind;
	assign move_value      = out_q.move_value;
	assign arm_angle_one   = out_q.arm_angle_one;
	assign arm_angle_two   = out_q.arm_angle_two;
	assign arm_angle_three = out_q.arm_angle_three;
	assign arm_setting     = out_q.arm_setting;
	assign audio_mode      = out_q.audio_mode;

endmodule

@@ src/cfdc_frame.sv @@
// Frame tracker: start hunt, byte collection, running check and held command values.
module cfdc_frame
	import cfdc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] byte_data,
	input  logic [7:0] start_symbol,
	output logic       last_byte,
	output logic       done,
	output result_t    result
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [7:0]         chk_q;
	logic [7:0]         rx_check_q;
	logic [7:0]         pay_q [PAY_FIRST:PAY_LAST];
	logic [7:0]         chk_final;
	logic               ok;
	logic               open_frame;
	logic               take_byte;
	result_t            held_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_HUNT: begin
				if (fire && byte_data == start_symbol) state_d = ST_COLLECT;
			end
			ST_COLLECT: begin
				if (fire && count_q == LAST_IDX) state_d = ST_HUNT;
			end
			default: state_d = ST_HUNT;
		endcase
	end

	// Decoded controls for the current state.
	always_comb begin
		open_frame = 1'b0;
		take_byte  = 1'b0;
		last_byte  = 1'b0;
		unique case (state_q)
			ST_HUNT: begin
				open_frame = fire && byte_data == start_symbol;
			end
			ST_COLLECT: begin
				take_byte = fire;
				last_byte = count_q == LAST_IDX;
			end
			default: ;
		endcase
	end

	assign done = take_byte && last_byte;

	// The last byte is the audio mode; fold it into the check here.
	assign chk_final = chk_step(chk_q, byte_data);
	assign ok        = chk_final == rx_check_q;

	// Result as it will be held after this frame.
	always_comb begin
		result          = held_q;
		result.frame_ok = ok;
		if (ok) begin
			result.motion_kind     = pay_q[1];
			result.move_value      = pay_q[2];
			result.arm_angle_one   = {pay_q[4], pay_q[3]};
			result.arm_angle_two   = {pay_q[6], pay_q[5]};
			result.arm_angle_three = {pay_q[8], pay_q[7]};
			result.arm_setting     = pay_q[9];
			result.audio_mode      = byte_data;
		end else begin
			result.motion_kind = BYTE_NONE;
			result.move_value  = BYTE_NONE;
			result.audio_mode  = BYTE_NONE;
		end
	end

	// State, position counter and running check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			count_q <= '0;
			chk_q   <= '0;
		end else begin
			state_q <= state_d;
			if (open_frame) begin
				count_q <= '0;
				chk_q   <= '0;
			end else if (take_byte) begin
				count_q <= last_byte ? '0 : count_q + 1'b1;
				if (count_q != CHECK_IDX) chk_q <= chk_step(chk_q, byte_data);
			end
		end
	end

	// Received check byte and payload bytes, each at its own position.
	always_ff @(posedge clk) begin
		if (take_byte && count_q == CHECK_IDX) rx_check_q <= byte_data;
		for (int i = PAY_FIRST; i <= PAY_LAST; i++) begin
			if (take_byte && count_q == CNT_W'(i)) pay_q[i] <= byte_data;
		end
	end

	// Held command values, kept across frames.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q.frame_ok        <= 1'b0;
			held_q.motion_kind     <= BYTE_NONE;
			held_q.move_value      <= BYTE_NONE;
			held_q.arm_angle_one   <= ANGLE_RESET;
			held_q.arm_angle_two   <= ANGLE_RESET;
			held_q.arm_angle_three <= ANGLE_RESET;
			held_q.arm_setting     <= BYTE_NONE;
			held_q.audio_mode      <= BYTE_NONE;
		end else if (done) begin
			held_q <= result;
		end
	end

endmodule

@@ src/cfdc_checker.sv @@
// Port-level checks for the command frame deframer, bound to the top level.
module cfdc_checker
	import cfdc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_we,
	input logic [7:0]         cfg_wdata,
	input logic               in_valid,
	input logic               in_stall,
	input logic [7:0]         rx_byte,
	input logic               out_valid,
	input logic               out_stall,
	input logic               frame_ok,
	input logic signed [7:0]  motion_kind,
	input logic signed [7:0]  move_value,
	input logic signed [15:0] arm_angle_one,
	input logic signed [15:0] arm_angle_two,
	input logic signed [15:0] arm_angle_three,
	input logic signed [7:0]  arm_setting,
	input logic signed [7:0]  audio_mode
);

	// A stalled result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_ok) && $stable(motion_kind)
			&& $stable(move_value) && $stable(arm_angle_one) && $stable(arm_angle_two)
			&& $stable(arm_angle_three) && $stable(arm_setting) && $stable(audio_mode))
		else $error("stalled result beat changed");

	// A stalled input beat stays offered with the same byte.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(rx_byte))
		else $error("stalled input beat changed");

	// A rejected frame reports the reject value in the cleared fields.
	a_reject_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_ok |-> motion_kind == BYTE_NONE && move_value == BYTE_NONE
			&& audio_mode == BYTE_NONE)
		else $error("rejected frame carries command values");

	// The input is only held back by a result that is waiting to be taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a pending result");

	// A start symbol write carries a known value.
	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !$isunknown(cfg_wdata))
		else $error("start symbol write with unknown data");

endmodule

bind command_frame_deframer_checker cfdc_checker u_cfdc_checker (.*);

@@ bench/tb_top.sv @@
// Self-checking testbench for the command frame deframer and checker.
`timescale 1ns / 1ps

module tb_top
	import cfdc_pkg::*;
();

	typedef logic [7:0] payload_t [10];

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 6;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [7:0]         cfg_wdata = 8'h00;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte   = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               frame_ok;
	logic signed [7:0]  motion_kind;
	logic signed [7:0]  move_value;
	logic signed [15:0] arm_angle_one;
	logic signed [15:0] arm_angle_two;
	logic signed [15:0] arm_angle_three;
	logic signed [7:0]  arm_setting;
	logic signed [7:0]  audio_mode;

	// Idle rates in percent, changed between test phases.
	int snd_idle_pct = 14;
	int rcv_idle_pct = 52;

	int error_count  = 0;
	int cycle_count  = 0;
	int beats_in     = 0;
	int beats_out    = 0;
	int frames_good  = 0;
	int frames_bad   = 0;
	int start_writes = 0;

	// Predictor state: its own copy of the deframer and its start symbol.
	logic [7:0]        pr_start;
	bit                pr_in_frame;
	int                pr_count;
	logic [7:0]        pr_check;
	payload_t          pr_payload;
	logic signed [7:0] pr_motion_kind;
	logic signed [7:0] pr_move_value;
	logic [15:0]       pr_angle [3];
	logic signed [7:0] pr_arm_setting;
	logic signed [7:0] pr_audio_mode;

	result_t expected_frames [$];

	command_frame_deframer_checker DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.frame_ok        (frame_ok),
		.motion_kind     (motion_kind),
		.move_value      (move_value),
		.arm_angle_one   (arm_angle_one),
		.arm_angle_two   (arm_angle_two),
		.arm_angle_three (arm_angle_three),
		.arm_setting     (arm_setting),
		.audio_mode      (audio_mode)
	);

	// Free-running clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Running check over the ten payload bytes: shift by 3 and OR, then by 4 and OR.
	function automatic logic [7:0] payload_checksum(input payload_t p);
		logic [7:0] ch;
		ch = 8'h00;
		for (int k = 0; k < 10; k++) begin
			ch = (ch << 3) | p[k];
			ch = (ch << 4) | p[k];
		end
		return ch;
	endfunction

	// Hunt noise that mostly avoids the start symbol, so most frames stay aligned.
	function automatic logic [7:0] noise_byte();
		logic [7:0] v;
		v = 8'($urandom_range(255));
		if (v == pr_start && $urandom_range(7) != 0)
			v = v + 8'd1;
		return v;
	endfunction

	task automatic report_error(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	task automatic reset_predictor();
		pr_start       = START_RESET;
		pr_in_frame    = 1'b0;
		pr_count       = 0;
		pr_motion_kind = BYTE_NONE;
		pr_move_value  = BYTE_NONE;
		foreach (pr_angle[k])
			pr_angle[k] = ANGLE_RESET;
		pr_arm_setting = BYTE_NONE;
		pr_audio_mode  = BYTE_NONE;
	endtask

	// Advance the predictor by one accepted byte; queue a result when a frame closes.
	task automatic deframe_predict(input logic [7:0] b);
		result_t r;
		bit      ok;
		if (!pr_in_frame) begin
			if (b == pr_start) begin
				pr_in_frame = 1'b1;
				pr_count    = 0;
			end
		end else begin
			if (pr_count == 0)
				pr_check = b;
			else
				pr_payload[pr_count-1] = b;
			pr_count++;
			if (pr_count == FRAME_BYTES) begin
				pr_in_frame = 1'b0;
				pr_count    = 0;
				ok = (payload_checksum(pr_payload) == pr_check);
				if (ok) begin
					pr_motion_kind = pr_payload[0];
					pr_move_value  = pr_payload[1];
					pr_angle[0]    = {pr_payload[3], pr_payload[2]};
					pr_angle[1]    = {pr_payload[5], pr_payload[4]};
					pr_angle[2]    = {pr_payload[7], pr_payload[6]};
					pr_arm_setting = pr_payload[8];
					pr_audio_mode  = pr_payload[9];
					frames_good++;
				end else begin
					pr_motion_kind = BYTE_NONE;
					pr_move_value  = BYTE_NONE;
					pr_audio_mode  = BYTE_NONE;
					frames_bad++;
				end
				r.frame_ok        = ok;
				r.motion_kind     = pr_motion_kind;
				r.move_value      = pr_move_value;
				r.arm_angle_one   = pr_angle[0];
				r.arm_angle_two   = pr_angle[1];
				r.arm_angle_three = pr_angle[2];
				r.arm_setting     = pr_arm_setting;
				r.audio_mode      = pr_audio_mode;
				expected_frames.push_back(r);
			end
		end
	endtask

	// Offer one byte after a random gap and hold it until the block takes the beat.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		deframe_predict(b);
		beats_in++;
	endtask

	// Start symbol, check byte (corrupted for a rejected frame), then the payload.
	task automatic send_frame(input payload_t p, input bit good);
		logic [7:0] chk;
		chk = payload_checksum(p);
		if (!good)
			chk = chk ^ 8'($urandom_range(255, 1));
		send_byte(pr_start);
		send_byte(chk);
		foreach (p[k])
			send_byte(p[k]);
	endtask

	// Finish any frame that stray noise has opened, so the block ends up hunting.
	task automatic flush_frame();
		while (pr_in_frame)
			send_byte(8'($urandom_range(255)));
	endtask

	// Wait until every expected result has come out, then let the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The start symbol is only changed while the block is idle and hunting.
	task automatic write_start_symbol(input logic [7:0] v);
		flush_frame();
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		pr_start  = v;
		start_writes++;
	endtask

	// Extreme bytes while hunting, then a rejected frame right after reset.
	task automatic test_hunt_and_reject();
		payload_t p;
		send_byte(8'h00);
		send_byte(8'hFF);
		foreach (p[k])
			p[k] = 8'(k * 37 + 1);
		send_frame(p, 1'b0);
	endtask

	// Accepted frame with extreme field values and the start symbol inside the payload.
	task automatic test_extreme_frame();
		payload_t p;
		p = '{8'h80, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'h7F,
			START_RESET, START_RESET, 8'hFF, 8'h00};
		send_frame(p, 1'b1);
	endtask

	// Mostly well-formed frames with random content, some bad checks and hunt noise.
	task automatic test_random_frames(input int n_bytes);
		payload_t p;
		int       sent;
		int       n_noise;
		sent = 0;
		while (sent < n_bytes) begin
			n_noise = $urandom_range(3);
			repeat (n_noise)
				send_byte(noise_byte());
			foreach (p[k]) begin
				case ($urandom_range(7))
					0: p[k] = pr_start;
					1: p[k] = $urandom_range(1) ? 8'h00 : 8'hFF;
					default: p[k] = 8'($urandom_range(255));
				endcase
			end
			send_frame(p, $urandom_range(3) != 0);
			sent += n_noise + FRAME_BYTES + 1;
		end
		flush_frame();
	endtask

	// Compare one result beat with the oldest expectation.
	task automatic check_result();
		result_t e;
		if (expected_frames.size() == 0) begin
			report_error("result beat with no frame expected");
		end else begin
			e = expected_frames.pop_front();
			if (frame_ok !== e.frame_ok)
				report_error($sformatf("beat %0d frame_ok got %b expected %b",
					beats_out, frame_ok, e.frame_ok));
			if (motion_kind !== e.motion_kind)
				report_error($sformatf("beat %0d motion_kind got %0d expected %0d",
					beats_out, motion_kind, e.motion_kind));
			if (move_value !== e.move_value)
				report_error($sformatf("beat %0d move_value got %0d expected %0d",
					beats_out, move_value, e.move_value));
			if (arm_angle_one !== e.arm_angle_one)
				report_error($sformatf("beat %0d arm_angle_one got %0d expected %0d",
					beats_out, arm_angle_one, e.arm_angle_one));
			if (arm_angle_two !== e.arm_angle_two)
				report_error($sformatf("beat %0d arm_angle_two got %0d expected %0d",
					beats_out, arm_angle_two, e.arm_angle_two));
			if (arm_angle_three !== e.arm_angle_three)
				report_error($sformatf("beat %0d arm_angle_three got %0d expected %0d",
					beats_out, arm_angle_three, e.arm_angle_three));
			if (arm_setting !== e.arm_setting)
				report_error($sformatf("beat %0d arm_setting got %0d expected %0d",
					beats_out, arm_setting, e.arm_setting));
			if (audio_mode !== e.audio_mode)
				report_error($sformatf("beat %0d audio_mode got %0d expected %0d",
					beats_out, audio_mode, e.audio_mode));
		end
		beats_out++;
	endtask

	// Result side: check each accepted beat and stall at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
		out_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results pending.",
				cycle_count, expected_frames.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		reset_predictor();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 14;
		rcv_idle_pct = 52;
		test_hunt_and_reject();
		test_extreme_frame();
		write_start_symbol(8'h00);
		test_random_frames(216);

		snd_idle_pct = 52;
		rcv_idle_pct = 14;
		write_start_symbol(8'hFF);
		test_random_frames(216);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		write_start_symbol(8'($urandom_range(255)));
		test_random_frames(108);
		write_start_symbol(START_RESET);
		test_random_frames(108);
		wait_idle();

		$display("Sent %0d bytes under %0d start symbol settings; checked %0d results.",
			beats_in, start_writes, beats_out);
		$display("Frames accepted: %0d, rejected: %0d, mismatches: %0d.",
			frames_good, frames_bad, error_count);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ command_frame_deframer_checker.f @@
src/cfdc_pkg.sv
src/cfdc_frame.sv
src/command_frame_deframer_checker.sv
src/cfdc_checker.sv
bench/tb_top.sv
